// ----- rtl/core/motion_cycle_upload_detector_core_defines.svh -----
// Assertion macros shared by the motion cycle upload detector RTL.
// Included by mcud_ctrl, the module that carries concurrent assertions; no other dependencies.
`ifndef MOTION_CYCLE_UPLOAD_DETECTOR_CORE_DEFINES_SVH
`define MOTION_CYCLE_UPLOAD_DETECTOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define MCUD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcud: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MCUD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcud: assertion failed");
`else
`define MCUD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCUD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/mcud_pkg.sv -----
// Shared constants, types and codes of the motion cycle upload detector.
// No dependencies; the RTL modules of the block use it by scoped names.
`default_nettype none

package mcud_pkg;

  // Sizes of the sample buffer and the cycle store.
  localparam int unsigned BUFFER_SAMPLES = 1600;
  localparam int unsigned MAX_CYCLES     = 54;

  localparam int unsigned IDX_W     = $clog2(MAX_CYCLES);
  localparam int unsigned CNT_W     = $clog2(MAX_CYCLES + 1);
  localparam int unsigned POS_W     = $clog2(BUFFER_SAMPLES);
  localparam int unsigned CD_W      = POS_W + 1;
  localparam int unsigned ACCEL_W   = 16;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [POS_W-1:0]        POS_LAST = POS_W'(BUFFER_SAMPLES - 1);
  localparam logic signed [CD_W-1:0]  CD_START = CD_W'(BUFFER_SAMPLES - 1);
  localparam logic [CNT_W-1:0]        CNT_MAX  = CNT_W'(MAX_CYCLES);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISC_THRESHOLD = 3'd0,
    CFG_MAG_THRESHOLD  = 3'd1,
    CFG_MIN_GAP        = 3'd2,
    CFG_MAX_GAP        = 3'd3,
    CFG_CRITICAL_COUNT = 3'd4,
    CFG_WAIT_FULL_MODE = 3'd5,
    CFG_ERASE_MARGIN   = 3'd6
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_DISC_THRESHOLD = 16'd1200;
  localparam logic [CFG_W-1:0] RST_MAG_THRESHOLD  = 16'd1005;
  localparam logic [CFG_W-1:0] RST_MIN_GAP        = 16'd30;
  localparam logic [CFG_W-1:0] RST_MAX_GAP        = 16'd400;
  localparam logic [CFG_W-1:0] RST_CRITICAL_COUNT = 16'd800;
  localparam logic             RST_WAIT_FULL_MODE = 1'b1;
  localparam logic [CFG_W-1:0] RST_ERASE_MARGIN   = 16'd4;

  typedef struct packed {
    logic [CFG_W-1:0] disc_threshold;
    logic [CFG_W-1:0] mag_threshold;
    logic [CFG_W-1:0] min_gap;
    logic [CFG_W-1:0] max_gap;
    logic [CFG_W-1:0] critical_count;
    logic             wait_full_mode;
    logic [CFG_W-1:0] erase_margin;
  } cfg_t;

  // Cycle store access requests.
  typedef struct packed {
    logic                     re;
    logic [IDX_W-1:0]         addr;
  } store_rd_t;

  typedef struct packed {
    logic                     we_stamp;
    logic                     we_cd;
    logic [IDX_W-1:0]         addr;
    logic [STAMP_W-1:0]       stamp;
    logic signed [CD_W-1:0]   cd;
  } store_wr_t;

  // One result beat.
  typedef struct packed {
    logic               upload;
    logic               cycle_detected;
    logic               buffer_full;
    logic [TOTAL_W-1:0] buffers_completed;
  } result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TAIL,
    ST_SUM,
    ST_DONE
  } ctrl_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/motion_cycle_upload_detector_core.sv -----
// Top level of the motion cycle upload detector: handshakes and result register.
// Depends on mcud_pkg, mcud_cfg_regs, mcud_cycle_store and mcud_ctrl.
`default_nettype none

// One sample beat yields one result beat. After a sample is accepted, the
// sequencer walks the held cycles (at most 54) one store entry per cycle over
// the single read port of the cycle store, then passes the tail, sum and done
// states, and in_ready_o stays low until the sequencer is idle again.
// The final state waits while an earlier result still sits unclaimed in the
// output register; a new sample is accepted while a finished result waits.
// Configuration is written through a plain write port while the block is idle:
// the user is bound to write only then, as the block itself does not enforce it.
module motion_cycle_upload_detector_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mcud_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mcud_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [mcud_pkg::ACCEL_W-1:0]    accel_i,
  input  wire logic [mcud_pkg::STAMP_W-1:0]    sample_time_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 upload_o,
  output logic                                 cycle_detected_o,
  output logic                                 buffer_full_o,
  output logic [mcud_pkg::TOTAL_W-1:0]         buffers_completed_o
);

  mcud_pkg::cfg_t      cfg;
  mcud_pkg::store_rd_t store_rd;
  mcud_pkg::store_wr_t store_wr;
  mcud_pkg::result_t   result;
  mcud_pkg::result_t   result_q;
  logic [mcud_pkg::STAMP_W-1:0]     rd_stamp;
  logic signed [mcud_pkg::CD_W-1:0] rd_cd;
  logic ctrl_idle;
  logic ctrl_done;
  logic start;
  logic out_free;
  logic out_valid_q, out_valid_d;

  mcud_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mcud_cycle_store u_cycle_store (
    .clk_i      (clk_i),
    .rd_i       (store_rd),
    .wr_i       (store_wr),
    .rd_stamp_o (rd_stamp),
    .rd_cd_o    (rd_cd)
  );

  mcud_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .accel_i    (accel_i),
    .stamp_i    (sample_time_i),
    .cfg_i      (cfg),
    .out_free_i (out_free),
    .idle_o     (ctrl_idle),
    .done_o     (ctrl_done),
    .result_o   (result),
    .rd_o       (store_rd),
    .wr_o       (store_wr),
    .rd_stamp_i (rd_stamp),
    .rd_cd_i    (rd_cd)
  );

  // Input side: a beat is taken whenever the sequencer is idle.
  assign in_ready_o = ctrl_idle;
  assign start      = in_valid_i && ctrl_idle;

  // Output register: free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_done) begin
      result_q <= result;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign upload_o            = result_q.upload;
  assign cycle_detected_o    = result_q.cycle_detected;
  assign buffer_full_o       = result_q.buffer_full;
  assign buffers_completed_o = result_q.buffers_completed;

endmodule

`default_nettype wire

// ----- rtl/core/mcud_cfg_regs.sv -----
// Configuration register file of the motion cycle upload detector.
// Depends on mcud_pkg for the register codes, reset values and cfg_t.
`default_nettype none

module mcud_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mcud_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mcud_pkg::CFG_W-1:0]      cfg_wdata_i,
  output mcud_pkg::cfg_t                       cfg_o
);

  mcud_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (mcud_pkg::cfg_idx_e'(cfg_idx_i))
        mcud_pkg::CFG_DISC_THRESHOLD: cfg_d.disc_threshold = cfg_wdata_i;
        mcud_pkg::CFG_MAG_THRESHOLD:  cfg_d.mag_threshold  = cfg_wdata_i;
        mcud_pkg::CFG_MIN_GAP:        cfg_d.min_gap        = cfg_wdata_i;
        mcud_pkg::CFG_MAX_GAP:        cfg_d.max_gap        = cfg_wdata_i;
        mcud_pkg::CFG_CRITICAL_COUNT: cfg_d.critical_count = cfg_wdata_i;
        mcud_pkg::CFG_WAIT_FULL_MODE: cfg_d.wait_full_mode = cfg_wdata_i[0];
        mcud_pkg::CFG_ERASE_MARGIN:   cfg_d.erase_margin   = cfg_wdata_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  // Register file with its reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disc_threshold <= mcud_pkg::RST_DISC_THRESHOLD;
      cfg_q.mag_threshold  <= mcud_pkg::RST_MAG_THRESHOLD;
      cfg_q.min_gap        <= mcud_pkg::RST_MIN_GAP;
      cfg_q.max_gap        <= mcud_pkg::RST_MAX_GAP;
      cfg_q.critical_count <= mcud_pkg::RST_CRITICAL_COUNT;
      cfg_q.wait_full_mode <= mcud_pkg::RST_WAIT_FULL_MODE;
      cfg_q.erase_margin   <= mcud_pkg::RST_ERASE_MARGIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/mcud_cycle_store.sv -----
// Cycle store: timestamps and countdowns of the held cycles, one entry per cycle.
// Depends on mcud_pkg for the access request types and widths.
`default_nettype none

module mcud_cycle_store (
  input  wire logic                              clk_i,
  input  wire mcud_pkg::store_rd_t               rd_i,
  input  wire mcud_pkg::store_wr_t               wr_i,
  output logic [mcud_pkg::STAMP_W-1:0]           rd_stamp_o,
  output logic signed [mcud_pkg::CD_W-1:0]       rd_cd_o
);

  logic [mcud_pkg::STAMP_W-1:0]     stamp_mem [mcud_pkg::MAX_CYCLES];
  logic signed [mcud_pkg::CD_W-1:0] cd_mem    [mcud_pkg::MAX_CYCLES];
  logic [mcud_pkg::STAMP_W-1:0]     rd_stamp_q;
  logic signed [mcud_pkg::CD_W-1:0] rd_cd_q;

  // Write port, shared address for both arrays.
  always_ff @(posedge clk_i) begin
    if (wr_i.we_stamp) begin
      stamp_mem[wr_i.addr] <= wr_i.stamp;
    end
    if (wr_i.we_cd) begin
      cd_mem[wr_i.addr] <= wr_i.cd;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rd_stamp_q <= stamp_mem[rd_i.addr];
      rd_cd_q    <= cd_mem[rd_i.addr];
    end
  end

  assign rd_stamp_o = rd_stamp_q;
  assign rd_cd_o    = rd_cd_q;

endmodule

`default_nettype wire

// ----- rtl/core/mcud_ctrl.sv -----
// Sequencer and shared datapath: walks the cycle store once per sample,
// ageing countdowns and summing cycle lengths, then detects and decides.
// Depends on mcud_pkg and on the assertion macros of the defines header.
`default_nettype none
`include "motion_cycle_upload_detector_core_defines.svh"

module mcud_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mcud_pkg::ACCEL_W-1:0]  accel_i,
  input  wire logic [mcud_pkg::STAMP_W-1:0]  stamp_i,
  input  wire mcud_pkg::cfg_t                cfg_i,
  input  wire logic                          out_free_i,
  output logic                               idle_o,
  output logic                               done_o,
  output mcud_pkg::result_t                  result_o,
  output mcud_pkg::store_rd_t                rd_o,
  output mcud_pkg::store_wr_t                wr_o,
  input  wire logic [mcud_pkg::STAMP_W-1:0]  rd_stamp_i,
  input  wire logic signed [mcud_pkg::CD_W-1:0] rd_cd_i
);

  mcud_pkg::ctrl_state_e state_q, state_d;

  // Persistent state across samples.
  logic [mcud_pkg::ACCEL_W-1:0] last_accel_q, last_accel_d;
  logic [mcud_pkg::POS_W-1:0]   buf_pos_q, buf_pos_d;
  logic [mcud_pkg::TOTAL_W-1:0] buf_total_q, buf_total_d;
  logic [mcud_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  // Per-sample working registers.
  logic [mcud_pkg::ACCEL_W-1:0] accel_q, accel_d;
  logic [mcud_pkg::STAMP_W-1:0] stamp_q, stamp_d;
  logic                         sample_ok_q, sample_ok_d;
  logic                         full_q, full_d;
  logic [mcud_pkg::IDX_W-1:0]   j_q, j_d;
  logic                         found_q, found_d;
  logic [mcud_pkg::CD_W-2:0]    first_q, first_d;
  logic [mcud_pkg::STAMP_W-1:0] prev_q, prev_d;
  logic [mcud_pkg::STAMP_W-1:0] len_q, len_d;
  logic                         len_vld_q, len_vld_d;
  logic [mcud_pkg::STAMP_W-1:0] sum_q, sum_d;
  logic                         detected_q, detected_d;

  // Combinational helpers.
  logic                         walk_last;
  logic [mcud_pkg::STAMP_W-1:0] sub_a;
  logic [mcud_pkg::STAMP_W-1:0] sub_res;
  logic [mcud_pkg::ACCEL_W-1:0] abs_diff;
  logic [mcud_pkg::POS_W-1:0]   pos_next;
  logic signed [mcud_pkg::CD_W-1:0] cd_dec;
  logic                         gap_ok;
  logic                         detect;
  logic [mcud_pkg::CNT_W-1:0]   cnt_new;
  logic                         enough;
  logic                         decide;
  logic [mcud_pkg::CNT_W-1:0]   j_cnt;
  logic                         store_we;
  logic [mcud_pkg::CNT_W-1:0]   wr_addr_cnt;

  assign walk_last = (mcud_pkg::CNT_W'(j_q) + mcud_pkg::CNT_W'(1)) == cnt_q;

  // The one shared subtractor: entry length while walking, gap at the tail.
  assign sub_a   = (state_q == mcud_pkg::ST_WALK) ? rd_stamp_i : stamp_q;
  assign sub_res = sub_a - prev_q;

  assign abs_diff = (accel_i > last_accel_q) ? (accel_i - last_accel_q)
                                              : (last_accel_q - accel_i);
  assign pos_next = (buf_pos_q == mcud_pkg::POS_LAST) ? '0
                                                     : (buf_pos_q + mcud_pkg::POS_W'(1));

  // Countdowns stop at minus one.
  assign cd_dec = rd_cd_i[mcud_pkg::CD_W-1] ? rd_cd_i
                                             : (rd_cd_i - mcud_pkg::CD_W'(1));

  assign gap_ok = (cnt_q == '0) ||
                  ((sub_res >= mcud_pkg::STAMP_W'(cfg_i.min_gap)) &&
                   (sub_res <= mcud_pkg::STAMP_W'(cfg_i.max_gap)));
  assign detect = sample_ok_q && gap_ok && (cnt_q < mcud_pkg::CNT_MAX);

  // Decision terms, used in the final state.
  assign cnt_new = cnt_q + mcud_pkg::CNT_W'(detected_q);
  assign enough  = sum_q >= mcud_pkg::STAMP_W'(cfg_i.critical_count);
  always_comb begin
    decide = 1'b0;
    if (cnt_new != '0) begin
      if (cfg_i.wait_full_mode) begin
        decide = full_q;
      end else begin
        decide = found_q &&
                 (mcud_pkg::CFG_W'(first_q) == cfg_i.erase_margin);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcud_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = (cnt_q != '0) ? mcud_pkg::ST_WALK : mcud_pkg::ST_TAIL;
        end
      end
      mcud_pkg::ST_WALK: begin
        if (walk_last) begin
          state_d = mcud_pkg::ST_TAIL;
        end
      end
      mcud_pkg::ST_TAIL: state_d = mcud_pkg::ST_SUM;
      mcud_pkg::ST_SUM:  state_d = mcud_pkg::ST_DONE;
      mcud_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = mcud_pkg::ST_IDLE;
        end
      end
      default: state_d = mcud_pkg::ST_IDLE;
    endcase
  end

  // Outputs: store requests and the result handshake.
  always_comb begin
    rd_o     = '0;
    wr_o     = '0;
    done_o   = 1'b0;
    idle_o   = 1'b0;
    unique case (state_q)
      mcud_pkg::ST_IDLE: begin
        idle_o  = 1'b1;
        rd_o.re = start_i && (cnt_q != '0);
      end
      mcud_pkg::ST_WALK: begin
        rd_o.re    = !walk_last;
        rd_o.addr  = j_q + mcud_pkg::IDX_W'(1);
        wr_o.we_cd = 1'b1;
        wr_o.addr  = j_q;
        wr_o.cd    = cd_dec;
      end
      mcud_pkg::ST_TAIL: begin
        wr_o.we_stamp = detect;
        wr_o.we_cd    = detect;
        wr_o.addr     = cnt_q[mcud_pkg::IDX_W-1:0];
        wr_o.stamp    = stamp_q;
        wr_o.cd       = mcud_pkg::CD_START;
      end
      mcud_pkg::ST_SUM: begin
        done_o = 1'b0;
      end
      mcud_pkg::ST_DONE: begin
        done_o = out_free_i;
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  assign result_o.upload            = decide && enough;
  assign result_o.cycle_detected    = detected_q;
  assign result_o.buffer_full       = full_q;
  assign result_o.buffers_completed = buf_total_q;

  // Datapath next values.
  always_comb begin
    last_accel_d = last_accel_q;
    buf_pos_d    = buf_pos_q;
    buf_total_d  = buf_total_q;
    cnt_d        = cnt_q;
    accel_d      = accel_q;
    stamp_d      = stamp_q;
    sample_ok_d  = sample_ok_q;
    full_d       = full_q;
    j_d          = j_q;
    found_d      = found_q;
    first_d      = first_q;
    prev_d       = prev_q;
    len_d        = len_q;
    len_vld_d    = 1'b0;
    sum_d        = sum_q;
    detected_d   = detected_q;

    // Accumulate the length registered on the previous cycle.
    if (len_vld_q && (len_q != '0) && !len_q[mcud_pkg::STAMP_W-1]) begin
      sum_d = sum_q + len_q;
    end

    unique case (state_q)
      mcud_pkg::ST_IDLE: begin
        if (start_i) begin
          accel_d     = accel_i;
          stamp_d     = stamp_i;
          sample_ok_d = (abs_diff >= cfg_i.disc_threshold) &&
                        ((accel_i >= cfg_i.mag_threshold) ||
                         (last_accel_q >= cfg_i.mag_threshold));
          buf_pos_d   = pos_next;
          full_d      = (pos_next == mcud_pkg::POS_LAST);
          if (pos_next == mcud_pkg::POS_LAST) begin
            buf_total_d = buf_total_q + mcud_pkg::TOTAL_W'(1);
          end
          j_d        = '0;
          found_d    = 1'b0;
          sum_d      = '0;
          detected_d = 1'b0;
        end
      end
      mcud_pkg::ST_WALK: begin
        if (!found_q && !cd_dec[mcud_pkg::CD_W-1]) begin
          found_d = 1'b1;
          first_d = cd_dec[mcud_pkg::CD_W-2:0];
        end
        len_d     = sub_res + mcud_pkg::STAMP_W'(1);
        len_vld_d = (j_q != '0);
        prev_d    = rd_stamp_i;
        j_d       = j_q + mcud_pkg::IDX_W'(1);
      end
      mcud_pkg::ST_TAIL: begin
        detected_d = detect;
        len_d      = sub_res + mcud_pkg::STAMP_W'(1);
        len_vld_d  = detect && (cnt_q != '0);
      end
      mcud_pkg::ST_SUM: begin
        len_vld_d = 1'b0;
      end
      mcud_pkg::ST_DONE: begin
        if (out_free_i) begin
          last_accel_d = accel_q;
          cnt_d        = decide ? '0 : cnt_new;
        end
      end
      default: begin
        len_vld_d = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mcud_pkg::ST_IDLE;
      last_accel_q <= '0;
      buf_pos_q    <= '0;
      buf_total_q  <= '0;
      cnt_q        <= '0;
      len_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_accel_q <= last_accel_d;
      buf_pos_q    <= buf_pos_d;
      buf_total_q  <= buf_total_d;
      cnt_q        <= cnt_d;
      len_vld_q    <= len_vld_d;
    end
  end

  // Working registers of the current sample.
  always_ff @(posedge clk_i) begin
    accel_q     <= accel_d;
    stamp_q     <= stamp_d;
    sample_ok_q <= sample_ok_d;
    full_q      <= full_d;
    j_q         <= j_d;
    found_q     <= found_d;
    first_q     <= first_d;
    prev_q      <= prev_d;
    len_q       <= len_d;
    sum_q       <= sum_d;
    detected_q  <= detected_d;
  end

  // Terms of the checks below.
  assign j_cnt       = mcud_pkg::CNT_W'(j_q);
  assign store_we    = wr_o.we_stamp || wr_o.we_cd;
  assign wr_addr_cnt = mcud_pkg::CNT_W'(wr_o.addr);

  // The store never holds more than its capacity.
  `MCUD_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= mcud_pkg::CNT_MAX)
  // Every store write lands inside the store.
  `MCUD_ASSERT_IMP(a_wr_addr, clk_i, rst_ni, store_we, wr_addr_cnt < mcud_pkg::CNT_MAX)
  // The walk only visits held entries.
  `MCUD_ASSERT_IMP(a_walk_bound, clk_i, rst_ni, state_q == mcud_pkg::ST_WALK, j_cnt < cnt_q)
  // A delivered result returns the sequencer to idle.
  `MCUD_ASSERT_NXT(a_done_idle, clk_i, rst_ni, done_o, state_q == mcud_pkg::ST_IDLE)
  // A new sample only starts while idle.
  `MCUD_ASSERT_IMP(a_start_idle, clk_i, rst_ni, start_i, state_q == mcud_pkg::ST_IDLE)

endmodule

`default_nettype wire
